// ----- sv/ptrl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrl_pkg
// Shared widths, codes and types of the per-tick rate limiter.
// ----------------------------------------------------------------------------
package ptrl_pkg;

  localparam int TAG_W       = 16;
  localparam int OUT_LEN_W   = 16;
  localparam int CNT_W       = 16;
  localparam int BYTES_W     = 24;
  localparam int BUF_MSGS_W  = 6;
  localparam int BUF_BYTES_W = 22;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int ACT_W       = 2;
  localparam int OC_W        = 3;
  localparam int WARN_W      = 4;

  localparam int MAX_REPLAY  = 32;
  localparam int REPLAY_W    = 6;

  localparam logic [CNT_W-1:0]   CNT_MAX   = 16'hFFFF;
  localparam logic [BYTES_W-1:0] BYTES_MAX = 24'hFFFFFF;

  // action codes
  localparam logic [ACT_W-1:0] ACT_MSG   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // outcome codes
  localparam logic [OC_W-1:0] OC_SENT      = 3'd0;
  localparam logic [OC_W-1:0] OC_QUEUED    = 3'd1;
  localparam logic [OC_W-1:0] OC_REJECTED  = 3'd2;
  localparam logic [OC_W-1:0] OC_DROPPED   = 3'd3;
  localparam logic [OC_W-1:0] OC_REPLAYED  = 3'd4;
  localparam logic [OC_W-1:0] OC_TICK_DONE = 3'd5;
  localparam logic [OC_W-1:0] OC_CLEARED   = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSGS_TICK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES_TICK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSGS_BUF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES_BUF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_MSGS_TICK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_BYTES_TICK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_MSGS_BUF   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_BYTES_BUF  = 3'd7;

  // warning flag bits
  localparam int WB_COUNT     = 0;
  localparam int WB_SIZE      = 1;
  localparam int WB_BUF_MSGS  = 2;
  localparam int WB_BUF_BYTES = 3;

  // commands from the controller to the backlog
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    logic rd_en;
  } bl_cmd_t;

endpackage

// ----- sv/ptrl_backlog.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrl_backlog
// Backlog ring: descriptor memory with registered head read, pointers,
// occupancy and buffered byte total.
// ----------------------------------------------------------------------------
module ptrl_backlog #(
  parameter int QUEUE_DEPTH = 32,
  parameter int LEN_BITS    = 16,
  localparam int PTR_W      = $clog2(QUEUE_DEPTH),
  localparam int OCC_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptrl_pkg::bl_cmd_t               cmd_i,
  input  logic [ptrl_pkg::TAG_W-1:0]      push_tag_i,
  input  logic [LEN_BITS-1:0]             push_len_i,
  output logic [OCC_W-1:0]                occ_o,
  output logic [ptrl_pkg::BUF_BYTES_W-1:0] buf_bytes_o,
  output logic [ptrl_pkg::TAG_W-1:0]      rd_tag_o,
  output logic [LEN_BITS-1:0]             rd_len_o
);

  localparam int ENTRY_W = ptrl_pkg::TAG_W + LEN_BITS;

  logic [ENTRY_W-1:0] mem_q [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_q;

  logic [PTR_W-1:0]                     head_q, head_d, tail_q, tail_d;
  logic [OCC_W-1:0]                     occ_q, occ_d;
  logic [ptrl_pkg::BUF_BYTES_W-1:0]     bytes_q, bytes_d;
  logic [ptrl_pkg::BUF_BYTES_W:0]       pop_len_ext;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign rd_tag_o    = rd_q[ENTRY_W-1:LEN_BITS];
  assign rd_len_o    = rd_q[LEN_BITS-1:0];
  assign occ_o       = occ_q;
  assign buf_bytes_o = bytes_q;

  // queued lengths always fit the byte total, but a wide length is guarded
  always_comb begin
    if (LEN_BITS > ptrl_pkg::BUF_BYTES_W) begin
      pop_len_ext = ((rd_len_o >> ptrl_pkg::BUF_BYTES_W) != '0) ?
                    {1'b1, {ptrl_pkg::BUF_BYTES_W{1'b0}}} :
                    (ptrl_pkg::BUF_BYTES_W + 1)'(rd_len_o);
    end else begin
      pop_len_ext = (ptrl_pkg::BUF_BYTES_W + 1)'(rd_len_o);
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    occ_d   = occ_q;
    bytes_d = bytes_q;
    if (cmd_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      occ_d   = '0;
      bytes_d = '0;
    end else if (cmd_i.push) begin
      tail_d  = next_ptr(tail_q);
      occ_d   = occ_q + OCC_W'(1);
      bytes_d = bytes_q + ptrl_pkg::BUF_BYTES_W'(push_len_i);
    end else if (cmd_i.pop) begin
      head_d  = next_ptr(head_q);
      occ_d   = occ_q - OCC_W'(1);
      bytes_d = ({1'b0, bytes_q} >= pop_len_ext) ?
                bytes_q - ptrl_pkg::BUF_BYTES_W'(pop_len_ext) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
      bytes_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      bytes_q <= bytes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail_q] <= {push_tag_i, push_len_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[head_q];
    end
  end

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> occ_q != '0)
    else $error("backlog pop while empty");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> occ_q < OCC_W'(QUEUE_DEPTH))
    else $error("backlog push while full");

  a_empty_no_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> (bytes_q == '0))
    else $error("empty backlog still holds bytes");

endmodule

// ----- sv/per_tick_rate_limiter_with_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_tick_rate_limiter_with_queue
// Per-tick message rate limiter with a backlog queue and warning flags.
// ----------------------------------------------------------------------------
// One event is handled at a time. A message or clear event is first taken into
// the event registers, then decided and loaded into the result register. A tick
// replays backlogged messages: each replay is a registered head read of the
// backlog memory followed by the limit check and pop. A stalled result register
// holds the sequence where it is. The backlog memory needs no clearing after
// reset.
module per_tick_rate_limiter_with_queue #(
  parameter int QUEUE_DEPTH = 32,
  parameter int LEN_BITS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ptrl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ptrl_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ptrl_pkg::ACT_W-1:0]         action_i,
  input  logic [ptrl_pkg::TAG_W-1:0]         msg_tag_i,
  input  logic [LEN_BITS-1:0]                msg_len_i,
  input  logic                               addr_matches_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ptrl_pkg::OC_W-1:0]          outcome_o,
  output logic [ptrl_pkg::TAG_W-1:0]         out_tag_o,
  output logic [ptrl_pkg::OUT_LEN_W-1:0]     out_len_o,
  output logic [ptrl_pkg::WARN_W-1:0]        warn_flags_o,
  output logic                               last_o
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = ((LEN_BITS > ptrl_pkg::BYTES_W) ? LEN_BITS : ptrl_pkg::BYTES_W) + 1;

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_IDLE     = 3'd0;
  localparam logic [STATE_W-1:0] S_DISP     = 3'd1;
  localparam logic [STATE_W-1:0] S_TK_READ  = 3'd2;
  localparam logic [STATE_W-1:0] S_TK_CHECK = 3'd3;
  localparam logic [STATE_W-1:0] S_TK_DONE  = 3'd4;

  // configuration
  logic [ptrl_pkg::CNT_W-1:0]       max_msgs_tick_q, warn_msgs_tick_q;
  logic [ptrl_pkg::BYTES_W-1:0]     max_bytes_tick_q, warn_bytes_tick_q;
  logic [ptrl_pkg::BUF_MSGS_W-1:0]  max_msgs_buf_q, warn_msgs_buf_q;
  logic [ptrl_pkg::BUF_BYTES_W-1:0] max_bytes_buf_q, warn_bytes_buf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msgs_tick_q   <= 16'd16;
      max_bytes_tick_q  <= 24'd4096;
      max_msgs_buf_q    <= 6'd32;
      max_bytes_buf_q   <= 22'd65536;
      warn_msgs_tick_q  <= 16'd64;
      warn_bytes_tick_q <= 24'd16384;
      warn_msgs_buf_q   <= 6'd16;
      warn_bytes_buf_q  <= 22'd32768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptrl_pkg::CFG_MAX_MSGS_TICK:   max_msgs_tick_q   <= cfg_data_i[15:0];
        ptrl_pkg::CFG_MAX_BYTES_TICK:  max_bytes_tick_q  <= cfg_data_i[23:0];
        ptrl_pkg::CFG_MAX_MSGS_BUF:    max_msgs_buf_q    <= cfg_data_i[5:0];
        ptrl_pkg::CFG_MAX_BYTES_BUF:   max_bytes_buf_q   <= cfg_data_i[21:0];
        ptrl_pkg::CFG_WARN_MSGS_TICK:  warn_msgs_tick_q  <= cfg_data_i[15:0];
        ptrl_pkg::CFG_WARN_BYTES_TICK: warn_bytes_tick_q <= cfg_data_i[23:0];
        ptrl_pkg::CFG_WARN_MSGS_BUF:   warn_msgs_buf_q   <= cfg_data_i[5:0];
        ptrl_pkg::CFG_WARN_BYTES_BUF:  warn_bytes_buf_q  <= cfg_data_i[21:0];
        default: ;
      endcase
    end
  end

  // control and counters
  logic [STATE_W-1:0]              state_q, state_d;
  logic [ptrl_pkg::REPLAY_W-1:0]   k_q, k_d;
  logic [ptrl_pkg::WARN_W-1:0]     warn_q, warn_d;
  logic [ptrl_pkg::CNT_W-1:0]      recv_count_q, recv_count_d, sent_count_q, sent_count_d;
  logic [ptrl_pkg::BYTES_W-1:0]    recv_bytes_q, recv_bytes_d, sent_bytes_q, sent_bytes_d;

  // latched event
  logic [ptrl_pkg::ACT_W-1:0]      req_action_q;
  logic [ptrl_pkg::TAG_W-1:0]      req_tag_q;
  logic [LEN_BITS-1:0]             req_len_q;
  logic                            req_match_q;

  // result register
  logic                            out_valid_q, out_valid_d, load;
  logic [ptrl_pkg::OC_W-1:0]       oc_q, oc_d;
  logic [ptrl_pkg::TAG_W-1:0]      tag_q, tag_d;
  logic [ptrl_pkg::OUT_LEN_W-1:0]  len_q, len_d;
  logic [ptrl_pkg::WARN_W-1:0]     flags_q;
  logic                            last_q, last_d;

  // backlog
  ptrl_pkg::bl_cmd_t                cmd;
  logic [OCC_W-1:0]                 occ;
  logic [ptrl_pkg::BUF_BYTES_W-1:0] buf_bytes;
  logic [ptrl_pkg::TAG_W-1:0]       rd_tag;
  logic [LEN_BITS-1:0]              rd_len;

  ptrl_backlog #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEN_BITS    (LEN_BITS)
  ) u_backlog (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .push_tag_i  (req_tag_q),
    .push_len_i  (req_len_q),
    .occ_o       (occ),
    .buf_bytes_o (buf_bytes),
    .rd_tag_o    (rd_tag),
    .rd_len_o    (rd_len)
  );

  // shared limit arithmetic: the sent length is the event's or the backlog head's
  logic [LEN_BITS-1:0]             sel_len;
  logic [SUM_W-1:0]                sent_sum, recv_sum, buf_sum;
  logic                            may_send, reject, out_free;
  logic [ptrl_pkg::BYTES_W-1:0]    sent_bytes_sat, recv_bytes_sat;
  logic [ptrl_pkg::CNT_W-1:0]      sent_count_inc, recv_count_inc;
  logic [ptrl_pkg::BUF_MSGS_W-1:0] occ6, occ6_inc;

  assign sel_len  = (state_q == S_TK_CHECK) ? rd_len : req_len_q;
  assign sent_sum = SUM_W'(sent_bytes_q) + SUM_W'(sel_len);
  assign recv_sum = SUM_W'(recv_bytes_q) + SUM_W'(req_len_q);
  assign buf_sum  = SUM_W'(buf_bytes) + SUM_W'(req_len_q);

  assign may_send = (sent_count_q <= max_msgs_tick_q) &&
                    (sent_sum <= SUM_W'(max_bytes_tick_q));

  assign sent_bytes_sat = (sent_sum > SUM_W'(ptrl_pkg::BYTES_MAX)) ?
                          ptrl_pkg::BYTES_MAX : sent_sum[ptrl_pkg::BYTES_W-1:0];
  assign recv_bytes_sat = (recv_sum > SUM_W'(ptrl_pkg::BYTES_MAX)) ?
                          ptrl_pkg::BYTES_MAX : recv_sum[ptrl_pkg::BYTES_W-1:0];
  assign sent_count_inc = (sent_count_q == ptrl_pkg::CNT_MAX) ?
                          sent_count_q : sent_count_q + ptrl_pkg::CNT_W'(1);
  assign recv_count_inc = (recv_count_q == ptrl_pkg::CNT_MAX) ?
                          recv_count_q : recv_count_q + ptrl_pkg::CNT_W'(1);

  assign occ6     = ptrl_pkg::BUF_MSGS_W'(occ);
  assign occ6_inc = occ6 + ptrl_pkg::BUF_MSGS_W'(1);

  assign reject = (occ6 >= max_msgs_buf_q) || (occ >= OCC_W'(QUEUE_DEPTH)) ||
                  (buf_sum >= SUM_W'(max_bytes_buf_q));

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    warn_d       = warn_q;
    recv_count_d = recv_count_q;
    recv_bytes_d = recv_bytes_q;
    sent_count_d = sent_count_q;
    sent_bytes_d = sent_bytes_q;
    cmd          = '0;
    load         = 1'b0;
    oc_d         = oc_q;
    tag_d        = tag_q;
    len_d        = len_q;
    last_d       = last_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (req_action_q)
          ptrl_pkg::ACT_MSG: begin
            if (out_free) begin
              load    = 1'b1;
              tag_d   = req_tag_q;
              len_d   = ptrl_pkg::OUT_LEN_W'(req_len_q);
              last_d  = 1'b1;
              state_d = S_IDLE;
              if (!req_match_q) begin
                oc_d = ptrl_pkg::OC_DROPPED;
              end else begin
                recv_count_d = recv_count_inc;
                recv_bytes_d = recv_bytes_sat;
                if (occ == '0 && may_send) begin
                  sent_count_d = sent_count_inc;
                  sent_bytes_d = sent_bytes_sat;
                  oc_d         = ptrl_pkg::OC_SENT;
                end else if (reject) begin
                  oc_d = ptrl_pkg::OC_REJECTED;
                end else begin
                  cmd.push = 1'b1;
                  if (occ6_inc >= warn_msgs_buf_q) begin
                    warn_d[ptrl_pkg::WB_BUF_MSGS] = 1'b1;
                  end
                  if (buf_sum >= SUM_W'(warn_bytes_buf_q)) begin
                    warn_d[ptrl_pkg::WB_BUF_BYTES] = 1'b1;
                  end
                  oc_d = ptrl_pkg::OC_QUEUED;
                end
              end
            end
          end
          ptrl_pkg::ACT_TICK: begin
            // receive warnings toggle: set only if they were clear
            warn_d[ptrl_pkg::WB_COUNT] = !warn_q[ptrl_pkg::WB_COUNT] &&
                                         (recv_count_q >= warn_msgs_tick_q);
            warn_d[ptrl_pkg::WB_SIZE]  = !warn_q[ptrl_pkg::WB_SIZE] &&
                                         (recv_bytes_q >= warn_bytes_tick_q);
            k_d     = '0;
            state_d = S_TK_READ;
          end
          ptrl_pkg::ACT_CLEAR: begin
            if (out_free) begin
              load      = 1'b1;
              oc_d      = ptrl_pkg::OC_CLEARED;
              tag_d     = '0;
              len_d     = '0;
              last_d    = 1'b1;
              cmd.clear = 1'b1;
              state_d   = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_TK_READ: begin
        if (occ != '0 && k_q < ptrl_pkg::REPLAY_W'(ptrl_pkg::MAX_REPLAY)) begin
          cmd.rd_en = 1'b1;
          state_d   = S_TK_CHECK;
        end else begin
          state_d = S_TK_DONE;
        end
      end
      S_TK_CHECK: begin
        if (!may_send) begin
          state_d = S_TK_DONE;
        end else if (out_free) begin
          load         = 1'b1;
          oc_d         = ptrl_pkg::OC_REPLAYED;
          tag_d        = rd_tag;
          len_d        = ptrl_pkg::OUT_LEN_W'(rd_len);
          last_d       = 1'b0;
          cmd.pop      = 1'b1;
          sent_count_d = sent_count_inc;
          sent_bytes_d = sent_bytes_sat;
          k_d          = k_q + ptrl_pkg::REPLAY_W'(1);
          state_d      = S_TK_READ;
        end
      end
      S_TK_DONE: begin
        if (out_free) begin
          if (occ6 < warn_msgs_buf_q) begin
            warn_d[ptrl_pkg::WB_BUF_MSGS] = 1'b0;
          end
          if (buf_bytes < warn_bytes_buf_q) begin
            warn_d[ptrl_pkg::WB_BUF_BYTES] = 1'b0;
          end
          if (sent_count_q < warn_msgs_tick_q) begin
            warn_d[ptrl_pkg::WB_COUNT] = 1'b0;
          end
          if (sent_bytes_q < warn_bytes_tick_q) begin
            warn_d[ptrl_pkg::WB_SIZE] = 1'b0;
          end
          load         = 1'b1;
          oc_d         = ptrl_pkg::OC_TICK_DONE;
          tag_d        = '0;
          len_d        = '0;
          last_d       = 1'b1;
          recv_count_d = '0;
          recv_bytes_d = '0;
          sent_count_d = '0;
          sent_bytes_d = '0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      k_q          <= '0;
      warn_q       <= '0;
      recv_count_q <= '0;
      recv_bytes_q <= '0;
      sent_count_q <= '0;
      sent_bytes_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      warn_q       <= warn_d;
      recv_count_q <= recv_count_d;
      recv_bytes_q <= recv_bytes_d;
      sent_count_q <= sent_count_d;
      sent_bytes_q <= sent_bytes_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // event beat is latched while idle
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_action_q <= action_i;
      req_tag_q    <= msg_tag_i;
      req_len_q    <= msg_len_i;
      req_match_q  <= addr_matches_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      oc_q    <= oc_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      flags_q <= warn_d;
      last_q  <= last_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign outcome_o    = oc_q;
  assign out_tag_o    = tag_q;
  assign out_len_o    = len_q;
  assign warn_flags_o = flags_q;
  assign last_o       = last_q;

  a_replay_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= ptrl_pkg::REPLAY_W'(ptrl_pkg::MAX_REPLAY))
    else $error("replay count beyond bound");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("result loaded over a waiting beat");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=>
      (out_valid_q && $stable({oc_q, tag_q, len_q, flags_q, last_q})))
    else $error("stalled result beat changed");

endmodule
